>>> src/fp_trap_instruction_decoder_defines.svh
// Assertion macros for the FP trap instruction decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FP_TRAP_INSTRUCTION_DECODER_DEFINES_SVH
`define FP_TRAP_INSTRUCTION_DECODER_DEFINES_SVH

// same-cycle implication, reset masked
`define FTID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftid same-cycle check failed");

// next-cycle implication, reset masked
`define FTID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftid next-cycle check failed");

`endif

>>> src/ftid_pkg.sv
// Package for the FP trap instruction decoder: types, codes, opcode table.
// No dependencies; used by ftid_decode and fp_trap_instruction_decoder.
`timescale 1ns / 1ps

package ftid_pkg;

  localparam logic [31:0] FPOP_MASK   = 32'hc1f80000;
  localparam logic [31:0] FPOP1_MATCH = 32'h81a00000;
  localparam logic [31:0] FPOP2_MATCH = 32'h81a80000;
  localparam logic [2:0]  TT_INVALID_REG = 3'd6;
  localparam logic [2:0]  TT_NONE        = 3'd0;

  localparam logic [1:0] SZ_NONE   = 2'd0;
  localparam logic [1:0] SZ_SINGLE = 2'd1;
  localparam logic [1:0] SZ_QUAD   = 2'd3;

  typedef enum logic [1:0] {
    ST_EMULATE  = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_BADREG   = 2'd3
  } ftid_status_t;

  typedef enum logic [1:0] {
    CLR_NONE  = 2'd0,
    CLR_LOWER = 2'd1,
    CLR_UPPER = 2'd2
  } ftid_clr_t;

  typedef struct packed {
    logic unit_used;
    logic lower_used;
    logic upper_used;
  } ftid_state_t;

  typedef struct packed {
    ftid_status_t status;
    logic [5:0]   op_index;
    logic [5:0]   src1_reg;
    logic [5:0]   src2_reg;
    logic [5:0]   dest_reg;
    logic         dest_is_fcc;
    logic         src1_zero;
    logic         src2_zero;
    logic         clear_status;
    ftid_clr_t    clear_bank;
    logic [2:0]   new_trap_type;
    logic         enable_fef;
  } ftid_res_t;

  // kind: [1:0] rs1 size, [3:2] rs2 size, [5:4] rd size, [11:8] trap type
  typedef struct packed {
    logic        hit;
    logic [5:0]  idx;
    logic [11:0] kind;
  } ftid_op_t;

  function automatic ftid_op_t op_lookup(input logic pop2, input logic [8:0] opf);
    ftid_op_t r;
    r = '0;
    r.hit = 1'b1;
    unique case ({pop2, opf})
      10'h003: begin r.idx = 6'd0;  r.kind = 12'h33c; end
      10'h007: begin r.idx = 6'd1;  r.kind = 12'h33c; end
      10'h00b: begin r.idx = 6'd2;  r.kind = 12'h33c; end
      10'h02b: begin r.idx = 6'd3;  r.kind = 12'h33c; end
      10'h043: begin r.idx = 6'd4;  r.kind = 12'h33f; end
      10'h047: begin r.idx = 6'd5;  r.kind = 12'h33f; end
      10'h04b: begin r.idx = 6'd6;  r.kind = 12'h33f; end
      10'h04f: begin r.idx = 6'd7;  r.kind = 12'h33f; end
      10'h06e: begin r.idx = 6'd8;  r.kind = 12'h33a; end
      10'h083: begin r.idx = 6'd9;  r.kind = 12'h32c; end
      10'h08c: begin r.idx = 6'd10; r.kind = 12'h338; end
      10'h0c7: begin r.idx = 6'd11; r.kind = 12'h31c; end
      10'h0cb: begin r.idx = 6'd12; r.kind = 12'h32c; end
      10'h0cc: begin r.idx = 6'd13; r.kind = 12'h334; end
      10'h0cd: begin r.idx = 6'd14; r.kind = 12'h334; end
      10'h0ce: begin r.idx = 6'd15; r.kind = 12'h338; end
      10'h0d3: begin r.idx = 6'd16; r.kind = 12'h31c; end
      10'h029: begin r.idx = 6'd17; r.kind = 12'h214; end
      10'h02a: begin r.idx = 6'd18; r.kind = 12'h228; end
      10'h041: begin r.idx = 6'd19; r.kind = 12'h215; end
      10'h042: begin r.idx = 6'd20; r.kind = 12'h22a; end
      10'h045: begin r.idx = 6'd21; r.kind = 12'h215; end
      10'h046: begin r.idx = 6'd22; r.kind = 12'h22a; end
      10'h049: begin r.idx = 6'd23; r.kind = 12'h215; end
      10'h04a: begin r.idx = 6'd24; r.kind = 12'h22a; end
      10'h04d: begin r.idx = 6'd25; r.kind = 12'h215; end
      10'h04e: begin r.idx = 6'd26; r.kind = 12'h22a; end
      10'h069: begin r.idx = 6'd27; r.kind = 12'h225; end
      10'h081: begin r.idx = 6'd28; r.kind = 12'h224; end
      10'h082: begin r.idx = 6'd29; r.kind = 12'h228; end
      10'h0c6: begin r.idx = 6'd30; r.kind = 12'h218; end
      10'h0c9: begin r.idx = 6'd31; r.kind = 12'h224; end
      10'h0d1: begin r.idx = 6'd32; r.kind = 12'h214; end
      10'h0d2: begin r.idx = 6'd33; r.kind = 12'h218; end
      10'h253: begin r.idx = 6'd34; r.kind = 12'h30f; end
      10'h257: begin r.idx = 6'd35; r.kind = 12'h30f; end
      default: begin r.hit = 1'b0; end
    endcase
    return r;
  endfunction

  // double and quad fields: bit 0 selects the upper bank
  function automatic logic [5:0] map_reg(input logic [1:0] size, input logic [4:0] field);
    if (size == SZ_SINGLE) begin
      return {1'b0, field};
    end
    return {field[0], field[4:1], 1'b0};
  endfunction

endpackage

>>> src/ftid_decode.sv
// Combinational decode of one trapped FPop word against current bank state.
// Depends on ftid_pkg.
`timescale 1ns / 1ps

module ftid_decode (
  input  logic [31:0]          instruction,
  input  logic [2:0]           trap_type,
  input  ftid_pkg::ftid_state_t st,
  output ftid_pkg::ftid_res_t  res,
  output ftid_pkg::ftid_state_t st_nxt
);
  import ftid_pkg::*;

  logic        grp_hit;
  logic        grp;
  ftid_op_t    lk;
  logic [1:0]  s1, s2, sd;
  logic [4:0]  f1, f2, fd;
  logic [5:0]  r1, r2, rd;
  logic        bad;

  assign grp_hit = ((instruction & FPOP_MASK) == FPOP1_MATCH) ||
                   ((instruction & FPOP_MASK) == FPOP2_MATCH);
  assign grp     = ((instruction & FPOP_MASK) == FPOP2_MATCH);
  assign lk      = op_lookup(grp, instruction[13:5]);

  assign s1 = lk.kind[1:0];
  assign s2 = lk.kind[3:2];
  assign sd = lk.kind[5:4];
  assign f1 = instruction[18:14];
  assign f2 = instruction[4:0];
  assign fd = instruction[29:25];
  assign r1 = map_reg(s1, f1);
  assign r2 = map_reg(s2, f2);
  assign rd = map_reg(sd, fd);

  assign bad = (s1 == SZ_QUAD && f1[1]) || (s2 == SZ_QUAD && f2[1]) ||
               (sd == SZ_QUAD && fd[1]);

  always_comb begin
    res = '0;
    res.new_trap_type = trap_type;
    st_nxt = st;
    if (!(grp_hit && lk.hit)) begin
      res.status = ST_UNKNOWN;
    end else if ({1'b0, trap_type} != lk.kind[11:8]) begin
      res.status = ST_MISMATCH;
    end else if (bad) begin
      res.status = ST_BADREG;
      res.new_trap_type = TT_INVALID_REG;
    end else begin
      res.status = ST_EMULATE;
      res.op_index = lk.idx;
      res.new_trap_type = TT_NONE;
      if (s1 != SZ_NONE) begin
        res.src1_reg  = r1;
        res.src1_zero = r1[5] ? !st.upper_used : !st.lower_used;
      end
      if (s2 != SZ_NONE) begin
        res.src2_reg  = r2;
        res.src2_zero = r2[5] ? !st.upper_used : !st.lower_used;
      end
      if (sd == SZ_NONE) begin
        res.dest_reg    = {4'b0, fd[1:0]};
        res.dest_is_fcc = 1'b1;
      end else begin
        res.dest_reg     = rd;
        res.enable_fef   = 1'b1;
        res.clear_status = !st.unit_used;
        st_nxt.unit_used = 1'b1;
        if (rd[5]) begin
          if (!st.upper_used) res.clear_bank = CLR_UPPER;
          st_nxt.upper_used = 1'b1;
        end else begin
          if (!st.lower_used) res.clear_bank = CLR_LOWER;
          st_nxt.lower_used = 1'b1;
        end
      end
    end
  end

endmodule

>>> src/fp_trap_instruction_decoder.sv
// Channel  Ports                               Direction
// in       in_valid/in_stall, instruction, tt  word in
// out      out_valid/out_stall, 12 fields      word out
//
// One word per cycle sustained while out_stall is low; each word is held in the input
// register and is then decoded into the result register.
// out_valid rises once the word has moved from the input register into the result register.
// rst_n (synchronous) clears valids and the unit/bank usage bits.
// out_stall holds the result; one more word waits in the input register.
// Top level of the FP trap instruction decoder; uses ftid_pkg, ftid_decode
// and the assertion macros header.
`timescale 1ns / 1ps
`include "fp_trap_instruction_decoder_defines.svh"

module fp_trap_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  input  logic [2:0]  in_trap_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_op_index,
  output logic [5:0]  out_src1_reg,
  output logic [5:0]  out_src2_reg,
  output logic [5:0]  out_dest_reg,
  output logic        out_dest_is_fcc,
  output logic        out_src1_zero,
  output logic        out_src2_zero,
  output logic        out_clear_status,
  output logic [1:0]  out_clear_bank,
  output logic [2:0]  out_new_trap_type,
  output logic        out_enable_fef
);
  import ftid_pkg::*;

  logic        ir_valid_r, ir_valid_nxt;
  logic [31:0] ir_ins_r;
  logic [2:0]  ir_tt_r;
  logic        out_valid_r, out_valid_nxt;
  ftid_res_t   res_r, res_nxt;
  ftid_state_t st_r, st_nxt;
  logic        out_free, ld, acc;

  assign out_free = !out_valid_r || !out_stall;
  assign ld       = ir_valid_r && out_free;
  assign in_stall = ir_valid_r && !out_free;
  assign acc      = in_valid && !in_stall;

  ftid_decode u_dec (
    .instruction (ir_ins_r),
    .trap_type   (ir_tt_r),
    .st          (st_r),
    .res         (res_nxt),
    .st_nxt      (st_nxt)
  );

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (acc) begin
      ir_valid_nxt = 1'b1;
    end else if (ld) begin
      ir_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      ir_valid_r  <= ir_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ld) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ir_ins_r <= in_instruction;
      ir_tt_r  <= in_trap_type;
    end
    if (ld) res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_op_index      = res_r.op_index;
  assign out_src1_reg      = res_r.src1_reg;
  assign out_src2_reg      = res_r.src2_reg;
  assign out_dest_reg      = res_r.dest_reg;
  assign out_dest_is_fcc   = res_r.dest_is_fcc;
  assign out_src1_zero     = res_r.src1_zero;
  assign out_src2_zero     = res_r.src2_zero;
  assign out_clear_status  = res_r.clear_status;
  assign out_clear_bank    = res_r.clear_bank;
  assign out_new_trap_type = res_r.new_trap_type;
  assign out_enable_fef    = res_r.enable_fef;

  `FTID_ASSERT_NOW(a_reject_clean, out_valid_r && res_r.status != ST_EMULATE, res_r.op_index == 6'd0 && !res_r.enable_fef && res_r.clear_bank == CLR_NONE)
  `FTID_ASSERT_NOW(a_fcc_no_write, out_valid_r && res_r.dest_is_fcc, !res_r.enable_fef && !res_r.clear_status)
  `FTID_ASSERT_NOW(a_clear_needs_write, out_valid_r && res_r.clear_bank != CLR_NONE, res_r.enable_fef && st_r.unit_used)
  `FTID_ASSERT_NEXT(a_unit_sticky, st_r.unit_used, st_r.unit_used)

endmodule

>>> tb/tb_fp_trap_instruction_decoder.sv
// Self-checking bench for fp_trap_instruction_decoder: a queue-fed driver,
// a stalling receiver and a monitor that checks every decoded word against
// an in-bench decode predictor. Depends on ftid_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_fp_trap_instruction_decoder;
  import ftid_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 400;
  localparam int QUIET_LO     = 700;
  localparam int QUIET_HI     = 900;
  localparam int PAUSE_AT     = 1000;

  typedef struct {
    logic [31:0] ins;
    logic [2:0]  tt;
    bit          wait_empty;
  } insn_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction = '0;
  logic [2:0]  in_trap_type = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_op_index;
  logic [5:0]  out_src1_reg;
  logic [5:0]  out_src2_reg;
  logic [5:0]  out_dest_reg;
  logic        out_dest_is_fcc;
  logic        out_src1_zero;
  logic        out_src2_zero;
  logic        out_clear_status;
  logic [1:0]  out_clear_bank;
  logic [2:0]  out_new_trap_type;
  logic        out_enable_fef;

  insn_item_t  insn_q[$];
  ftid_res_t   pending_decodes[$];

  logic unit_seen = 1'b0;
  logic lower_seen = 1'b0;
  logic upper_seen = 1'b0;

  int   errors = 0;
  int   n_sent = 0;
  int   n_recv = 0;
  int   cycles = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  bit   send_gap;
  bit   quiet;
  int   status_seen [4] = '{0, 0, 0, 0};

  fp_trap_instruction_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_instruction   (in_instruction),
    .in_trap_type     (in_trap_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_op_index     (out_op_index),
    .out_src1_reg     (out_src1_reg),
    .out_src2_reg     (out_src2_reg),
    .out_dest_reg     (out_dest_reg),
    .out_dest_is_fcc  (out_dest_is_fcc),
    .out_src1_zero    (out_src1_zero),
    .out_src2_zero    (out_src2_zero),
    .out_clear_status (out_clear_status),
    .out_clear_bank   (out_clear_bank),
    .out_new_trap_type(out_new_trap_type),
    .out_enable_fef   (out_enable_fef)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // {pop2, opf, kind}; kind: [1:0] rs1, [3:2] rs2, [5:4] rd size, [11:8] trap type
  function automatic logic [21:0] op_row(input int i);
    case (i)
      0:  return {1'b0, 9'h003, 12'h33c};
      1:  return {1'b0, 9'h007, 12'h33c};
      2:  return {1'b0, 9'h00b, 12'h33c};
      3:  return {1'b0, 9'h02b, 12'h33c};
      4:  return {1'b0, 9'h043, 12'h33f};
      5:  return {1'b0, 9'h047, 12'h33f};
      6:  return {1'b0, 9'h04b, 12'h33f};
      7:  return {1'b0, 9'h04f, 12'h33f};
      8:  return {1'b0, 9'h06e, 12'h33a};
      9:  return {1'b0, 9'h083, 12'h32c};
      10: return {1'b0, 9'h08c, 12'h338};
      11: return {1'b0, 9'h0c7, 12'h31c};
      12: return {1'b0, 9'h0cb, 12'h32c};
      13: return {1'b0, 9'h0cc, 12'h334};
      14: return {1'b0, 9'h0cd, 12'h334};
      15: return {1'b0, 9'h0ce, 12'h338};
      16: return {1'b0, 9'h0d3, 12'h31c};
      17: return {1'b0, 9'h029, 12'h214};
      18: return {1'b0, 9'h02a, 12'h228};
      19: return {1'b0, 9'h041, 12'h215};
      20: return {1'b0, 9'h042, 12'h22a};
      21: return {1'b0, 9'h045, 12'h215};
      22: return {1'b0, 9'h046, 12'h22a};
      23: return {1'b0, 9'h049, 12'h215};
      24: return {1'b0, 9'h04a, 12'h22a};
      25: return {1'b0, 9'h04d, 12'h215};
      26: return {1'b0, 9'h04e, 12'h22a};
      27: return {1'b0, 9'h069, 12'h225};
      28: return {1'b0, 9'h081, 12'h224};
      29: return {1'b0, 9'h082, 12'h228};
      30: return {1'b0, 9'h0c6, 12'h218};
      31: return {1'b0, 9'h0c9, 12'h224};
      32: return {1'b0, 9'h0d1, 12'h214};
      33: return {1'b0, 9'h0d2, 12'h218};
      34: return {1'b1, 9'h053, 12'h30f};
      35: return {1'b1, 9'h057, 12'h30f};
      default: return '0;
    endcase
  endfunction

  function automatic logic [5:0] phys_reg(input logic [1:0] size, input logic [4:0] field);
    if (size == SZ_SINGLE) begin
      return {1'b0, field};
    end
    return {field[0], field[4:1], 1'b0};
  endfunction

  function automatic logic bank_in_use(input logic [5:0] r);
    return r[5] ? upper_seen : lower_seen;
  endfunction

  // decode one trapped word; updates the usage bits like the block does
  function automatic ftid_res_t decode_word(input logic [31:0] ins, input logic [2:0] tt);
    ftid_res_t   r;
    logic        grp_ok;
    logic [9:0]  key;
    logic [21:0] row;
    logic [11:0] kind;
    logic [1:0]  s1, s2, sd;
    logic [4:0]  f1, f2, fd;
    logic [5:0]  rd;
    int          idx;
    r = '0;
    r.status = ST_UNKNOWN;
    r.new_trap_type = tt;
    idx = -1;
    kind = '0;
    grp_ok = 1'b1;
    key = '0;
    if ((ins & FPOP_MASK) == FPOP1_MATCH) begin
      key = {1'b0, ins[13:5]};
    end else if ((ins & FPOP_MASK) == FPOP2_MATCH) begin
      key = {1'b1, ins[13:5]};
    end else begin
      grp_ok = 1'b0;
    end
    for (int i = 0; i < 36; i++) begin
      row = op_row(i);
      if (grp_ok && idx < 0 && row[21:12] == key) begin
        idx = i;
        kind = row[11:0];
      end
    end
    if (idx < 0) begin
      return r;
    end
    if (kind[11:8] != {1'b0, tt}) begin
      r.status = ST_MISMATCH;
      return r;
    end
    s1 = kind[1:0];
    s2 = kind[3:2];
    sd = kind[5:4];
    f1 = ins[18:14];
    f2 = ins[4:0];
    fd = ins[29:25];
    if ((s1 == SZ_QUAD && f1[1]) || (s2 == SZ_QUAD && f2[1]) || (sd == SZ_QUAD && fd[1])) begin
      r.status = ST_BADREG;
      r.new_trap_type = TT_INVALID_REG;
      return r;
    end
    r.status = ST_EMULATE;
    r.op_index = idx[5:0];
    r.new_trap_type = TT_NONE;
    if (s1 != SZ_NONE) begin
      r.src1_reg = phys_reg(s1, f1);
      r.src1_zero = !bank_in_use(r.src1_reg);
    end
    if (s2 != SZ_NONE) begin
      r.src2_reg = phys_reg(s2, f2);
      r.src2_zero = !bank_in_use(r.src2_reg);
    end
    if (sd == SZ_NONE) begin
      r.dest_reg = {4'b0, fd[1:0]};
      r.dest_is_fcc = 1'b1;
    end else begin
      rd = phys_reg(sd, fd);
      r.dest_reg = rd;
      r.enable_fef = 1'b1;
      if (!unit_seen) begin
        r.clear_status = 1'b1;
        unit_seen = 1'b1;
      end
      if (!bank_in_use(rd)) begin
        r.clear_bank = rd[5] ? CLR_UPPER : CLR_LOWER;
      end
      if (rd[5]) begin
        upper_seen = 1'b1;
      end else begin
        lower_seen = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_raw(input logic [31:0] ins, input logic [2:0] tt, input bit wait_empty);
    insn_item_t it;
    it.ins = ins;
    it.tt = tt;
    it.wait_empty = wait_empty;
    insn_q.push_back(it);
  endtask

  task automatic add_op(input int i, input logic [2:0] tt, input logic [4:0] fd,
                        input logic [4:0] f1, input logic [4:0] f2);
    logic [21:0] row;
    row = op_row(i);
    add_raw((row[21] ? FPOP2_MATCH : FPOP1_MATCH) | {2'b00, fd, 6'b0, f1, row[20:12], f2},
            tt, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  assign quiet = (n_sent >= QUIET_LO) && (n_sent < QUIET_HI);

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_decodes.push_back(decode_word(in_instruction, in_trap_type));
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        send_gap = !quiet && (hold_cnt == 0) && ($urandom_range(0, 99) < 31);
        if (insn_q.size() != 0 && !send_gap &&
            !(insn_q[0].wait_empty && pending_decodes.size() != 0)) begin
          in_valid <= 1'b1;
          in_instruction <= insn_q[0].ins;
          in_trap_type <= insn_q[0].tt;
          void'(insn_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end else if (!hold_done && n_recv >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        $error("result word with no expected decode pending");
        errors++;
      end else begin
        check_field("status", 32'(pending_decodes[0].status), 32'(out_status));
        check_field("op_index", 32'(pending_decodes[0].op_index), 32'(out_op_index));
        check_field("src1_reg", 32'(pending_decodes[0].src1_reg), 32'(out_src1_reg));
        check_field("src2_reg", 32'(pending_decodes[0].src2_reg), 32'(out_src2_reg));
        check_field("dest_reg", 32'(pending_decodes[0].dest_reg), 32'(out_dest_reg));
        check_field("dest_is_fcc", 32'(pending_decodes[0].dest_is_fcc),
                    32'(out_dest_is_fcc));
        check_field("src1_zero", 32'(pending_decodes[0].src1_zero), 32'(out_src1_zero));
        check_field("src2_zero", 32'(pending_decodes[0].src2_zero), 32'(out_src2_zero));
        check_field("clear_status", 32'(pending_decodes[0].clear_status),
                    32'(out_clear_status));
        check_field("clear_bank", 32'(pending_decodes[0].clear_bank), 32'(out_clear_bank));
        check_field("new_trap_type", 32'(pending_decodes[0].new_trap_type),
                    32'(out_new_trap_type));
        check_field("enable_fef", 32'(pending_decodes[0].enable_fef), 32'(out_enable_fef));
        status_seen[pending_decodes[0].status]++;
        void'(pending_decodes.pop_front());
      end
      n_recv++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          pick;
    int          i;
    logic [31:0] w;
    logic [2:0]  tt;
    logic [21:0] row;

    // unrecognized words, tt extremes
    add_raw(32'h0000_0000, 3'd0, 1'b0);
    add_raw(32'hffff_ffff, 3'd7, 1'b0);
    add_raw(FPOP2_MATCH | (32'h003 << 5), 3'd3, 1'b0);
    add_raw(FPOP1_MATCH | (32'h1ff << 5), 3'd3, 1'b0);
    // trap type mismatch, quad and subnormal class
    add_op(4, 3'd2, 5'd0, 5'd0, 5'd0);
    add_op(19, 3'd3, 5'd0, 5'd0, 5'd0);
    add_op(19, 3'd0, 5'd0, 5'd0, 5'd0);
    add_op(34, 3'd7, 5'd0, 5'd0, 5'd0);
    // odd-pair quad register in each operand, then the first write (status and lower bank clear)
    add_op(4, 3'd3, 5'd0, 5'd2, 5'd0);
    add_op(4, 3'd3, 5'd0, 5'd0, 5'd2);
    add_op(4, 3'd3, 5'd2, 5'd0, 5'd0);
    add_op(16, 3'd3, 5'd30, 5'd0, 5'd0);
    // compare after that write: upper-bank sources read as zero, no clears
    add_op(34, 3'd3, 5'd3, 5'd5, 5'd29);
    // further writes: upper bank clear, later writes clear nothing
    add_op(20, 3'd2, 5'd31, 5'd31, 5'd0);
    add_op(19, 3'd2, 5'd31, 5'd31, 5'd31);
    add_op(19, 3'd2, 5'd0, 5'd0, 5'd0);
    add_op(35, 3'd3, 5'd0, 5'd29, 5'd28);
    add_op(33, 3'd2, 5'd31, 5'd31, 5'd31);
    add_op(0, 3'd3, 5'd29, 5'd0, 5'd29);
    add_op(8, 3'd3, 5'd28, 5'd28, 5'd28);
    add_op(27, 3'd2, 5'd31, 5'd31, 5'd31);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      w = $urandom;
      tt = 3'($urandom_range(0, 7));
      if (pick < 75) begin
        i = $urandom_range(0, 35);
        row = op_row(i);
        w = (w & ~FPOP_MASK) | (row[21] ? FPOP2_MATCH : FPOP1_MATCH);
        w[13:5] = row[20:12];
        if ($urandom_range(0, 99) < 85) begin
          tt = row[10:8];
        end
        // mostly even-pair register fields so quad ops get through
        if ($urandom_range(0, 3) != 0) begin
          w[15] = 1'b0;
          w[1] = 1'b0;
          w[26] = 1'b0;
        end
      end else if (pick < 90) begin
        w = (w & ~FPOP_MASK) | ($urandom_range(0, 1) ? FPOP2_MATCH : FPOP1_MATCH);
      end
      add_raw(w, tt, (n == 0) || (n == PAUSE_AT));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (insn_q.size() != 0 || in_valid || pending_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      $error("%0d expected decodes never arrived", pending_decodes.size());
      errors++;
    end

    $display("Sent %0d instruction words, checked %0d decoded words in %0d cycles",
             n_sent, n_recv, cycles);
    $display("Outcomes emulate/unknown/mismatch/bad-reg: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
